[hw/rtl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor: widths, control
// characters, result kinds, controller states and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

   // line store geometry
   localparam int LINE_MAX = 32;
   localparam int ADDR_W   = $clog2(LINE_MAX);
   localparam int LEN_W    = $clog2(LINE_MAX + 1);

   // capacity register
   localparam int             CAP_W     = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd32;

   // control characters
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // input modes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_DROP = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ECHO,
      ST_ERASE_BS1,
      ST_ERASE_SP,
      ST_ERASE_BS2,
      ST_EOL_CR,
      ST_EOL_LF,
      ST_LINE,
      ST_END
   } state_type;

   // source of the result byte
   typedef enum logic [2:0] {
      SEL_BYTE,
      SEL_CR,
      SEL_LF,
      SEL_BS,
      SEL_SPACE,
      SEL_MEM,
      SEL_ZERO
   } out_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        load_item;
      logic        len_clear;
      logic        len_inc;
      logic        len_dec;
      logic        store_wr;
      logic        calc_n;
      logic        cnt_clear;
      logic        cnt_inc;
      logic        out_load;
      logic [1:0]  out_kind;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_drop;
      logic cap_zero;
      logic is_eol;
      logic is_erase;
      logic is_print;
      logic len_empty;
      logic len_full;
      logic line_done;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/cle_req_if.sv]
// ----------------------------------------------------------------------------
// cle_req_if
// Input channel: one received console byte or a drop-line event per word.
// ----------------------------------------------------------------------------
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

[hw/rtl/cle_rsp_if.sv]
// ----------------------------------------------------------------------------
// cle_rsp_if
// Result channel: echo bytes, completed line bytes and line end markers.
// ----------------------------------------------------------------------------
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output kind, output out_byte, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

[hw/rtl/cle_datapath.sv]
// ----------------------------------------------------------------------------
// cle_datapath
// Holds the capacity register, the received word, the line store and its
// length, the line dump counter and the result output register.
// ----------------------------------------------------------------------------
module cle_datapath
   import cle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   input  logic             in_mode,
   input  logic [7:0]       in_byte,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte,
   output logic             rsp_last
);

   logic [CAP_W-1:0] cap_ff;
   logic             mode_ff;
   logic [7:0]       byte_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] n_ff;
   logic [7:0]       rd_data_ff;
   logic [7:0]       line_mem [LINE_MAX];
   logic             out_valid_ff;
   logic [1:0]       out_kind_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic [CAP_W-1:0] cap_m1;
   logic [LEN_W-1:0] n_in;
   logic [7:0]       sel_byte;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // received word
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= in_mode;
         byte_ff <= in_byte;
      end
   end

   // line length
   always_comb begin
      len_in = len_ff;
      if (cmd.len_clear) begin
         len_in = '0;
      end else if (cmd.len_inc) begin
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.len_dec) begin
         len_in = len_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // dump length: line truncated to capacity minus one
   assign cap_m1 = cap_ff - CAP_W'(1);
   assign n_in   = (CAP_W'(len_ff) > cap_m1) ? cap_m1[LEN_W-1:0] : len_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_n) begin
         n_ff <= n_in;
      end
   end

   // dump counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   // line store, read data tracks the next dump position
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         line_mem[len_ff[ADDR_W-1:0]] <= byte_ff;
      end
      rd_data_ff <= line_mem[cnt_in[ADDR_W-1:0]];
   end

   // result byte select
   always_comb begin
      case (cmd.out_sel)
         SEL_BYTE:  sel_byte = byte_ff;
         SEL_CR:    sel_byte = CH_CR;
         SEL_LF:    sel_byte = CH_LF;
         SEL_BS:    sel_byte = CH_BS;
         SEL_SPACE: sel_byte = CH_SPACE;
         SEL_MEM:   sel_byte = rd_data_ff;
         SEL_ZERO:  sel_byte = 8'h00;
         default:   sel_byte = 8'h00;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff <= cmd.out_kind;
         out_byte_ff <= sel_byte;
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;

   // status to controller
   always_comb begin
      status.is_drop   = (mode_ff == MODE_DROP);
      status.cap_zero  = (cap_ff == '0);
      status.is_eol    = (byte_ff == CH_CR) || (byte_ff == CH_LF);
      status.is_erase  = (byte_ff == CH_DEL) || (byte_ff == CH_BS);
      status.is_print  = (byte_ff >= CH_SPACE) && (byte_ff < CH_DEL);
      status.len_empty = (len_ff == '0);
      status.len_full  = (len_ff >= LEN_W'(LINE_MAX - 1));
      status.line_done = (cnt_ff == n_ff);
      status.out_free  = !out_valid_ff || rsp_ready;
   end

endmodule

[hw/rtl/cle_ctrl.sv]
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller: takes one word at a time, classifies it and sequences the
// echo, line dump and end marker results into the datapath.
// ----------------------------------------------------------------------------
module cle_ctrl
   import cle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.out_kind  = KIND_ECHO;
      cmd.out_sel   = SEL_ZERO;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            if (status.is_drop) begin
               cmd.len_clear = 1'b1;
            end else if (status.cap_zero) begin
               state_in = ST_IDLE;
            end else if (status.is_eol) begin
               cmd.calc_n    = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_EOL_CR;
            end else if (status.is_erase) begin
               if (!status.len_empty) begin
                  cmd.len_dec = 1'b1;
                  state_in    = ST_ERASE_BS1;
               end
            end else if (status.is_print && !status.len_full) begin
               state_in = ST_ECHO;
            end
         end

         // printable byte: echo and append
         ST_ECHO: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_BYTE;
               cmd.out_last = 1'b1;
               cmd.store_wr = 1'b1;
               cmd.len_inc  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // erase: BS, space, BS
         ST_ERASE_BS1: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_BS;
               state_in     = ST_ERASE_SP;
            end
         end

         ST_ERASE_SP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_SPACE;
               state_in     = ST_ERASE_BS2;
            end
         end

         ST_ERASE_BS2: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_BS;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // end of line: CR LF echo
         ST_EOL_CR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_CR;
               state_in     = ST_EOL_LF;
            end
         end

         ST_EOL_LF: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_LF;
               state_in     = ST_LINE;
            end
         end

         // line dump, one stored byte per word
         ST_LINE: begin
            if (status.line_done) begin
               state_in = ST_END;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_LINE;
               cmd.out_sel  = SEL_MEM;
               cmd.cnt_inc  = 1'b1;
            end
         end

         // end marker, line cleared
         ST_END: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_END;
               cmd.out_sel   = SEL_ZERO;
               cmd.out_last  = 1'b1;
               cmd.len_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/console_line_editor.sv]
// ----------------------------------------------------------------------------
// console_line_editor
// Console line editor: echoes typed bytes, handles erase, and dumps the
// completed line with an end marker on CR or LF.
// ----------------------------------------------------------------------------
// One word is taken at a time; req_if.ready is high only while the controller
// is idle, and the next word may be taken while the final result of the
// previous one still sits in the output register. An end of line emits the
// stored line bytes, up to capacity minus one, from the line store read
// port, one per cycle while rsp_if does not stall. Capacity must be written
// through csr_we/csr_wdata only while the block is idle; the block does not
// enforce this itself. It resets to 32.
module console_line_editor
   import cle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cle_req_if.sink          req_if,
   cle_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // controller
   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   cle_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_mode   (req_if.mode),
      .in_byte   (req_if.data_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_kind  (rsp_if.kind),
      .rsp_byte  (rsp_if.out_byte),
      .rsp_last  (rsp_if.last)
   );

endmodule

[hw/rtl/cle_checker.sv]
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker
   import cle_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   // one word at a time: no new word right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while previous one still in work");

   // end marker carries a zero byte and closes the word
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |-> (rsp_byte == 8'h00) && rsp_last)
      else $error("malformed line end marker");

   // a line byte is never the final result of a word
   a_line_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_LINE) |-> !rsp_last)
      else $error("line byte flagged as last");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_byte) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind console_line_editor cle_checker u_cle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_kind  (rsp_if.kind),
   .rsp_byte  (rsp_if.out_byte),
   .rsp_last  (rsp_if.last)
);
